// ===== design/alternating_bit_receiver_ack_drop_unit_defines.svh =====
// Assertion macros for the alternating-bit receiver unit.
// Expects signals named clock and reset in the module that uses them.
// Compiled out when SYNTH is defined.
`ifndef ALTERNATING_BIT_RECEIVER_ACK_DROP_UNIT_DEFINES_SVH
`define ALTERNATING_BIT_RECEIVER_ACK_DROP_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define ABRAD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abrad assertion failed");

// Next-cycle implication, checked outside reset.
`define ABRAD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abrad assertion failed");

`else

`define ABRAD_ASSERT_IMP(lbl, ante, cons)
`define ABRAD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/abrad_pkg.sv =====
// Package for the alternating-bit receiver unit: constants, result type,
// and the Park-Miller generator helpers. No dependencies.
package abrad_pkg;

   localparam int LEN_W      = 13;
   localparam int SEQ_W      = 8;
   localparam int GEN_W      = 31;
   localparam int BYTES_W    = 40;
   localparam int COUNT_W    = 32;
   localparam int LEN_CMP_W  = 17;     // holds the largest supported packet size
   localparam int MULT_W     = 15;
   localparam int PROD_W     = GEN_W + MULT_W;

   localparam int MAX_PACKET_BYTES_DEF = 4096;

   localparam logic [MULT_W-1:0] PM_MULT    = 15'd16807;
   localparam logic [GEN_W-1:0]  PM_MOD     = 31'h7FFF_FFFF;
   localparam logic [SEQ_W-1:0]  DIGIT_ZERO = 8'd48;

   // csr register indexes
   localparam logic REG_DROP_THRESHOLD = 1'b0;
   localparam logic REG_GENERATOR_SEED = 1'b1;

   typedef struct packed {
      logic                 ack_sent;
      logic                 new_packet;
      logic                 transfer_done;
      logic [BYTES_W-1:0]   bytes_total;
      logic [BYTES_W-1:0]   payload_total;
      logic [COUNT_W-1:0]   packets_accepted;
      logic [COUNT_W-1:0]   resends_seen;
   } rsp_type;

   // Seed 0 is a fixed point of the generator and 2^31-1 steps to it; map them to 1.
   function automatic logic [GEN_W-1:0] seed_to_state(input logic [GEN_W-1:0] s);
      logic [GEN_W-1:0] r;
      r = s;
      if (s == '0 || s == PM_MOD) begin
         r = GEN_W'(1);
      end
      return r;
   endfunction

   // x * 16807 mod (2^31-1): fold the high bits onto the low bits, then one
   // conditional subtract, since the folded sum stays below twice the modulus.
   function automatic logic [GEN_W-1:0] pm_next(input logic [GEN_W-1:0] x);
      logic [PROD_W-1:0] p;
      logic [GEN_W:0]    s;
      logic [GEN_W:0]    m;
      p = PROD_W'(PM_MULT) * PROD_W'(x);
      s = (GEN_W+1)'(p[PROD_W-1:GEN_W]) + (GEN_W+1)'(p[GEN_W-1:0]);
      m = {1'b0, PM_MOD};
      if (s >= m) begin
         s = s - m;
      end
      return s[GEN_W-1:0];
   endfunction

endpackage

// ===== design/alternating_bit_receiver_ack_drop_unit.sv =====
// Alternating-bit receiver with pseudo-random ACK dropping (top level).
// Depends on abrad_pkg and alternating_bit_receiver_ack_drop_unit_defines.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  req     | in        | req_valid / req_ready | packet_length, sequence_byte
//  rsp     | out       | rsp_valid / rsp_ready | ack/new/done flags and four totals
//  csr     | in        | csr_write_enable      | csr_index, csr_wdata (31 bits)
//
// One packet summary per cycle sustained while rsp_ready holds. A req
// transfer passes the input register, then the result register, to
// rsp_valid; the generator step (15x31 multiply plus Mersenne fold) and the
// saturating counter adds sit between the two. Reset is synchronous; there
// is no clearing pass. A stalled rsp holds the result register, the input
// register keeps the next item, and req_ready drops only when both are full.
`include "alternating_bit_receiver_ack_drop_unit_defines.svh"

module alternating_bit_receiver_ack_drop_unit
   import abrad_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [LEN_W-1:0]   req_packet_length,
   input  logic [SEQ_W-1:0]   req_sequence_byte,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ack_sent,
   output logic               rsp_new_packet,
   output logic               rsp_transfer_done,
   output logic [BYTES_W-1:0] rsp_bytes_total,
   output logic [BYTES_W-1:0] rsp_payload_total,
   output logic [COUNT_W-1:0] rsp_packets_accepted,
   output logic [COUNT_W-1:0] rsp_resends_seen,

   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [GEN_W-1:0]   csr_wdata
);

   localparam logic [LEN_CMP_W-1:0] MaxBytes = LEN_CMP_W'(MAX_PACKET_BYTES);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [LEN_W-1:0]   in_len_ff;
   logic [SEQ_W-1:0]   in_seq_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // protocol state and configuration
   logic               expected_bit_ff, expected_bit_in;
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic [BYTES_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [COUNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [COUNT_W-1:0] resend_cnt_ff, resend_cnt_in;
   logic [GEN_W-1:0]   threshold_ff, threshold_in;

   // datapath
   logic               advance;
   logic               is_end;
   logic               is_new;
   logic [LEN_W-1:0]   len_clip;
   logic [GEN_W-1:0]   gen_step;
   logic [BYTES_W:0]   byte_sum;
   logic [BYTES_W-1:0] acc_wide;

   // Item in the input register moves on when the result register is free
   // or is being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign is_end   = (in_len_ff == '0);
   assign len_clip = ({{(LEN_CMP_W-LEN_W){1'b0}}, in_len_ff} > MaxBytes) ?
                     MaxBytes[LEN_W-1:0] : in_len_ff;
   assign gen_step = pm_next(gen_ff);
   assign is_new   = (in_seq_ff == (DIGIT_ZERO + SEQ_W'(expected_bit_ff)));
   assign byte_sum = {1'b0, byte_cnt_ff} + (BYTES_W+1)'(len_clip);

   always_comb begin
      in_valid_in     = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in  = 1'b1;
      end else if (advance) begin
         in_valid_in  = 1'b0;
      end

      rsp_valid_in    = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      threshold_in    = threshold_ff;
      expected_bit_in = expected_bit_ff;
      gen_in          = gen_ff;
      byte_cnt_in     = byte_cnt_ff;
      acc_cnt_in      = acc_cnt_ff;
      resend_cnt_in   = resend_cnt_ff;

      // end of transfer leaves every counter and the generator untouched
      if (advance && !is_end) begin
         gen_in = gen_step;
         if (is_new) begin
            expected_bit_in = !expected_bit_ff;
            byte_cnt_in     = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
            if (acc_cnt_ff != '1) begin
               acc_cnt_in   = acc_cnt_ff + COUNT_W'(1);
            end
         end else if (resend_cnt_ff != '1) begin
            resend_cnt_in   = resend_cnt_ff + COUNT_W'(1);
         end
      end

      // user must write csr only while idle, never racing an item; not enforced
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_DROP_THRESHOLD: threshold_in = csr_wdata;
            REG_GENERATOR_SEED: gen_in       = seed_to_state(csr_wdata);
            default:            threshold_in = threshold_ff;
         endcase
      end

      // result reports the totals after this item's update
      acc_wide                = BYTES_W'(acc_cnt_in);
      rsp_in.ack_sent         = !is_end && (gen_step > threshold_ff);
      rsp_in.new_packet       = !is_end && is_new;
      rsp_in.transfer_done    = is_end;
      rsp_in.bytes_total      = byte_cnt_in;
      rsp_in.payload_total    = (byte_cnt_in >= acc_wide) ? (byte_cnt_in - acc_wide) : '0;
      rsp_in.packets_accepted = acc_cnt_in;
      rsp_in.resends_seen     = resend_cnt_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         threshold_ff    <= '0;
         expected_bit_ff <= 1'b0;
         gen_ff          <= GEN_W'(1);
         byte_cnt_ff     <= '0;
         acc_cnt_ff      <= '0;
         resend_cnt_ff   <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         threshold_ff    <= threshold_in;
         expected_bit_ff <= expected_bit_in;
         gen_ff          <= gen_in;
         byte_cnt_ff     <= byte_cnt_in;
         acc_cnt_ff      <= acc_cnt_in;
         resend_cnt_ff   <= resend_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_len_ff <= req_packet_length;
         in_seq_ff <= req_sequence_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ack_sent         = rsp_ff.ack_sent;
   assign rsp_new_packet       = rsp_ff.new_packet;
   assign rsp_transfer_done    = rsp_ff.transfer_done;
   assign rsp_bytes_total      = rsp_ff.bytes_total;
   assign rsp_payload_total    = rsp_ff.payload_total;
   assign rsp_packets_accepted = rsp_ff.packets_accepted;
   assign rsp_resends_seen     = rsp_ff.resends_seen;

   // checks
   `ABRAD_ASSERT_IMP(a_gen_nonfixed, 1'b1, (gen_ff != '0) && (gen_ff != PM_MOD))
   `ABRAD_ASSERT_NXT(a_advance_fills_rsp, advance, rsp_valid_ff)
   `ABRAD_ASSERT_NXT(a_new_toggles_bit, advance && !is_end && is_new,
                     expected_bit_ff != $past(expected_bit_ff))
   `ABRAD_ASSERT_IMP(a_done_no_ack, rsp_valid_ff && rsp_ff.transfer_done,
                     !rsp_ff.ack_sent && !rsp_ff.new_packet)
   `ABRAD_ASSERT_IMP(a_payload_bound, rsp_valid_ff,
                     rsp_ff.payload_total <= rsp_ff.bytes_total)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for alternating_bit_receiver_ack_drop_unit.
// Needs abrad_pkg and the unit; it holds its own model of the receiver,
// drives random packet summaries with random stalls and checks every response.
module tb_top;
   import abrad_pkg::*;

   localparam int CLK_PERIOD = 8;
   localparam int MAX_LEN = MAX_PACKET_BYTES_DEF;
   localparam logic [SEQ_W-1:0] DIGIT_ONE = DIGIT_ZERO + 8'd1;
   localparam longint unsigned GEN_MULT = 64'd16807;
   localparam longint unsigned GEN_MODULUS = 64'h7FFF_FFFF;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct {
      logic [LEN_W-1:0] pkt_len;
      logic [SEQ_W-1:0] seq_byte;
   } packet_type;

   // clock, reset and every block input start at known values
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [LEN_W-1:0] req_packet_length = '0;
   logic [SEQ_W-1:0] req_sequence_byte = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_ack_sent;
   logic rsp_new_packet;
   logic rsp_transfer_done;
   logic [BYTES_W-1:0] rsp_bytes_total;
   logic [BYTES_W-1:0] rsp_payload_total;
   logic [COUNT_W-1:0] rsp_packets_accepted;
   logic [COUNT_W-1:0] rsp_resends_seen;

   logic csr_write_enable = 1'b0;
   logic csr_index = REG_DROP_THRESHOLD;
   logic [GEN_W-1:0] csr_wdata = '0;

   alternating_bit_receiver_ack_drop_unit #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES_DEF)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_packet_length(req_packet_length),
      .req_sequence_byte(req_sequence_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ack_sent(rsp_ack_sent),
      .rsp_new_packet(rsp_new_packet),
      .rsp_transfer_done(rsp_transfer_done),
      .rsp_bytes_total(rsp_bytes_total),
      .rsp_payload_total(rsp_payload_total),
      .rsp_packets_accepted(rsp_packets_accepted),
      .rsp_resends_seen(rsp_resends_seen),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Receiver model: register copies plus the protocol state.
   // ---------------------------------------------------------------------
   logic [GEN_W-1:0]   drop_level = '0;       // drop threshold
   logic [GEN_W-1:0]   lfsr_state = 31'd1;    // generator value (reset seed 1)
   logic               want_bit = 1'b0;       // alternating bit expected next
   logic [BYTES_W-1:0] byte_sum = '0;
   logic [COUNT_W-1:0] accept_count = '0;
   logic [COUNT_W-1:0] dup_count = '0;

   rsp_type expected_rsps[$];   // responses owed by the unit, oldest first
   packet_type pending_pkts[$]; // summaries waiting to be driven
   int      mismatch_count = 0;

   // idle percentages, changed only between phases
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // stimulus-side copy of the alternating bit, so well-formed streams can be built
   logic tx_bit = 1'b0;

   // minimal-standard step, done the plain way with a 64-bit remainder
   function automatic logic [GEN_W-1:0] park_miller_step(input logic [GEN_W-1:0] x);
      longint unsigned p;
      p = GEN_MULT * longint'(x);
      return GEN_W'(p % GEN_MODULUS);
   endfunction

   // Apply one accepted summary to the model and queue the response it owes.
   task automatic receive_packet(input logic [LEN_W-1:0] len_in,
                                 input logic [SEQ_W-1:0] seq_in);
      rsp_type r;
      logic [LEN_W-1:0] len;
      logic [BYTES_W:0] sum;
      r = '0;
      if (len_in == '0) begin
         // end of transfer: no generator step, totals reported as they stand
         r.transfer_done = 1'b1;
      end else begin
         len = (len_in > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_in;
         lfsr_state = park_miller_step(lfsr_state);
         r.ack_sent = (lfsr_state > drop_level);
         if (seq_in == DIGIT_ZERO + SEQ_W'(want_bit)) begin
            r.new_packet = 1'b1;
            want_bit = ~want_bit;
            sum = {1'b0, byte_sum} + (BYTES_W + 1)'(len);
            byte_sum = (sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : sum[BYTES_W-1:0];
            if (accept_count != COUNT_MAX) begin
               accept_count = accept_count + COUNT_W'(1);
            end
         end else if (dup_count != COUNT_MAX) begin
            // wrong digit or any other byte is a resend
            dup_count = dup_count + COUNT_W'(1);
         end
      end
      r.bytes_total = byte_sum;
      r.payload_total = (byte_sum >= BYTES_W'(accept_count)) ?
                        byte_sum - BYTES_W'(accept_count) : '0;
      r.packets_accepted = accept_count;
      r.resends_seen = dup_count;
      expected_rsps.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: one summary per transfer; valid holds until the unit takes it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      packet_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            receive_packet(req_packet_length, req_sequence_byte);
         end
         if (req_valid && !req_ready) begin
            // stalled: keep valid and payload as they are
         end else if (pending_pkts.size() != 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_pkts.pop_front();
            req_valid <= 1'b1;
            req_packet_length <= nxt.pkt_len;
            req_sequence_byte <= nxt.seq_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compares each response transfer with the oldest expectation
   // and throttles rsp_ready at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response transfer with no expectation outstanding");
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("ack_sent", 64'(want.ack_sent), 64'(rsp_ack_sent));
               check_field("new_packet", 64'(want.new_packet), 64'(rsp_new_packet));
               check_field("transfer_done", 64'(want.transfer_done),
                           64'(rsp_transfer_done));
               check_field("bytes_total", 64'(want.bytes_total), 64'(rsp_bytes_total));
               check_field("payload_total", 64'(want.payload_total),
                           64'(rsp_payload_total));
               check_field("packets_accepted", 64'(want.packets_accepted),
                           64'(rsp_packets_accepted));
               check_field("resends_seen", 64'(want.resends_seen),
                           64'(rsp_resends_seen));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Queue a summary and track the alternating bit the unit will expect next.
   task automatic queue_packet(input logic [LEN_W-1:0] len,
                               input logic [SEQ_W-1:0] seq);
      packet_type p;
      p.pkt_len = len;
      p.seq_byte = seq;
      pending_pkts.push_back(p);
      if (len != '0 && seq == DIGIT_ZERO + SEQ_W'(tx_bit)) begin
         tx_bit = ~tx_bit;
      end
   endtask

   // Mostly a well-behaved sender; some stale digits, junk bytes and
   // end-of-transfer markers mixed in.
   task automatic queue_random_packet();
      logic [LEN_W-1:0] len;
      logic [SEQ_W-1:0] seq;
      int kind;
      int len_kind;
      len_kind = $urandom_range(99);
      if (len_kind < 60) begin
         len = LEN_W'($urandom_range(MAX_LEN, 1));
      end else if (len_kind < 75) begin
         len = LEN_W'($urandom_range(16, 1));
      end else if (len_kind < 85) begin
         len = LEN_W'(MAX_LEN);
      end else begin
         // oversized, clamps to the receive buffer size
         len = LEN_W'($urandom_range((1 << LEN_W) - 1, MAX_LEN + 1));
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
         seq = DIGIT_ZERO + SEQ_W'(tx_bit);
      end else if (kind < 82) begin
         seq = DIGIT_ZERO + SEQ_W'(~tx_bit);
      end else if (kind < 93) begin
         seq = SEQ_W'($urandom_range(255));
      end else begin
         len = '0;
         seq = SEQ_W'($urandom_range(255));
      end
      queue_packet(len, seq);
   endtask

   // Register write; the model follows as the write is driven. Only called idle.
   task automatic write_csr(input logic idx, input logic [GEN_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == REG_DROP_THRESHOLD) begin
         drop_level = val;
      end else if (idx == REG_GENERATOR_SEED) begin
         // zero is a fixed point and the modulus steps to it, so both load as one
         lfsr_state = (val == '0 || val == GEN_W'(GEN_MODULUS)) ? GEN_W'(1) : val;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until nothing is queued, in flight or owed. Sampled on the
   // falling edge so every rising-edge update has settled.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_pkts.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   task automatic run_phase(input logic [GEN_W-1:0] thr, input logic [GEN_W-1:0] seed,
                            input int sidle, input int rstall, input int n,
                            input bit pause_mid);
      write_csr(REG_DROP_THRESHOLD, thr);
      write_csr(REG_GENERATOR_SEED, seed);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < n; i++) begin
         queue_random_packet();
         // hold the sender until the unit has fully drained, then resume
         if (pause_mid && i == n / 2) begin
            wait_drained();
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings (threshold 0: every ACK goes out).
      queue_packet(13'd0, DIGIT_ZERO);       // end of transfer before any data
      queue_packet(13'd1, DIGIT_ZERO);       // first new packet
      queue_packet(13'd4096, DIGIT_ONE);     // largest legal length
      queue_packet(13'd4096, DIGIT_ONE);     // duplicate
      queue_packet(13'd4097, DIGIT_ZERO);    // oversized, clamped
      queue_packet(13'h1FFF, DIGIT_ONE);     // all-ones length, clamped
      queue_packet(13'd100, DIGIT_ONE);      // stale digit
      queue_packet(13'd2, 8'h00);            // non-digit bytes count as resends
      queue_packet(13'd2, 8'hFF);
      queue_packet(13'd5, 8'h41);
      queue_packet(13'd0, 8'hFF);            // end of transfer, state kept
      queue_packet(13'd3, DIGIT_ZERO);       // transfer carries on
      queue_packet(13'd7, 8'h32);            // digit two
      queue_packet(13'h1FFF, DIGIT_ZERO);    // oversized resend
      queue_packet(13'd1, DIGIT_ONE);
      queue_packet(13'd0, DIGIT_ONE);
      queue_packet(13'd12, DIGIT_ZERO);
      wait_drained();

      // Random phases over threshold and seed extremes and all idle mixes.
      run_phase(31'h7FFF_FFFE, 31'h7FFF_FFFE, 0, 0, 250, 1'b0);  // every ACK dropped
      run_phase(31'd0, 31'd0, 59, 0, 250, 1'b0);                 // zero seed
      run_phase(GEN_W'($urandom_range(32'h7FFF_FFFE)), 31'h7FFF_FFFF,
                0, 59, 250, 1'b0);                               // modulus seed
      run_phase(31'h4000_0000, GEN_W'($urandom_range(32'h7FFF_FFFE, 1)),
                16, 16, 250, 1'b1);
      run_phase(GEN_W'($urandom_range(32'h7FFF_FFFE)), 31'd1, 0, 0, 250, 1'b0);
      run_phase(GEN_W'($urandom_range(32'h7FFF_FFFE)),
                GEN_W'($urandom_range(32'h7FFF_FFFE, 1)), 59, 59, 250, 1'b0);

      // a few more edges to catch any stray response
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLK_PERIOD * 300000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/abrad_pkg.sv
design/alternating_bit_receiver_ack_drop_unit.sv
tb/tb_top.sv
